// ===== src/dsag_pkg.sv =====
// ----------------------------------------------------------------------------
// dsag_pkg: shared types and constants of the dual strided address generator
// Widths, opcodes, register indexes, state codes and the cell control
// and status bundles used by the axis cells and the core.
// ----------------------------------------------------------------------------
package dsag_pkg;

  // number of axis cells in the chain
  localparam int MAX_AXES = 8;

  // field widths
  localparam int AXIS_COUNT_W = 4;
  localparam int AXIS_W       = 3;
  localparam int EXTENT_W     = 16;
  localparam int ADDR_W       = 32;
  localparam int OPCODE_W     = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  // width of the active rank after clamping to the number of cells
  localparam int RANK_W = $clog2(MAX_AXES + 1);

  // item opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AXIS_COUNT = 2'd0,
    CFG_SRC_BASE   = 2'd1,
    CFG_DST_BASE   = 2'd2
  } cfg_reg_t;

  // core sequencer states
  typedef enum logic {
    ST_READY = 1'b0,
    ST_WALK  = 1'b1
  } state_t;

  // core to cell control
  typedef struct packed {
    logic load;    // write this axis descriptor
    logic clear;   // start of traversal, zero the index counter
    logic inject;  // step begins at this cell
  } cell_ctl_t;

  // cell to core status
  typedef struct packed {
    logic tok;       // cell holds the carry token this cycle
    logic wrap;      // counter reaches its extent on this increment
    logic ext_zero;  // stored extent is zero
  } cell_stat_t;

  // active rank, saturated at the number of cells
  function automatic logic [RANK_W-1:0] clamp_rank(input logic [AXIS_COUNT_W-1:0] cnt);
    logic [RANK_W-1:0] r;
    if (int'(cnt) > MAX_AXES) begin
      r = RANK_W'(MAX_AXES);
    end else begin
      r = RANK_W'(cnt);
    end
    return r;
  endfunction

endpackage

// ===== src/dsag_if.sv =====
// ----------------------------------------------------------------------------
// dsag_if: item channels of the dual strided address generator
// Valid/ready channels for command items and address result items.
// ----------------------------------------------------------------------------

// command item channel
interface dsag_in_if;
  import dsag_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [AXIS_W-1:0]   axis;
  logic [EXTENT_W-1:0] extent;
  logic [ADDR_W-1:0]   src_stride;
  logic [ADDR_W-1:0]   dst_stride;

  modport source (output valid, opcode, axis, extent, src_stride, dst_stride, input ready);
  modport sink   (input valid, opcode, axis, extent, src_stride, dst_stride, output ready);
endinterface

// address result item channel
interface dsag_out_if;
  import dsag_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_address;
  logic [ADDR_W-1:0] dst_address;
  logic              last;

  modport source (output valid, src_address, dst_address, last, input ready);
  modport sink   (input valid, src_address, dst_address, last, output ready);
endinterface

// ===== src/dual_strided_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// dual_strided_address_generator_core: nested-loop address generator
// Walks a tensor of up to MAX_AXES axes like an odometer and emits paired
// source and destination element addresses, one pair per step item while running.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------
//   in_ch   | in  | valid/ready        | opcode, axis, extent, strides
//   out_ch  | out | valid/ready        | src_address, dst_address, last
//   cfg_*   | in  | cfg_we             | cfg_index, cfg_wdata
//
// Load and start items are handled when accepted. A step item injects the
// carry token at the innermost active axis (rank zero: done at once) and ends
// when it stops or leaves axis 0, the token moving one cell per cycle.
// Reset clears counters, offsets and control; descriptors are undefined
// until loaded, with no clearing pass. in_ch.ready is low while a step walks
// the chain and while a finished result waits on a stalled out_ch.
// ----------------------------------------------------------------------------
module dual_strided_address_generator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  dsag_in_if.sink                          in_ch,
  dsag_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dsag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dsag_pkg::*;

  // configuration registers
  logic [AXIS_COUNT_W-1:0] axis_count_r;
  logic [ADDR_W-1:0]       src_base_r;
  logic [ADDR_W-1:0]       dst_base_r;

  // sequencer and running offsets
  state_t            state_r, state_nxt;
  logic              running_r, running_nxt;
  logic [ADDR_W-1:0] src_off_r, src_off_nxt;
  logic [ADDR_W-1:0] dst_off_r, dst_off_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_src_r, out_src_nxt;
  logic [ADDR_W-1:0] out_dst_r, out_dst_nxt;
  logic              out_last_r, out_last_nxt;

  // chain wiring
  cell_ctl_t         ctl   [MAX_AXES];
  cell_stat_t        stat  [MAX_AXES];
  logic              carry [MAX_AXES];
  logic [ADDR_W-1:0] sdel  [MAX_AXES];
  logic [ADDR_W-1:0] ddel  [MAX_AXES];

  logic [RANK_W-1:0] rank;
  logic [ADDR_W-1:0] src_prod, dst_prod;
  logic [ADDR_W-1:0] src_rewind, dst_rewind;
  logic [ADDR_W-1:0] src_delta, dst_delta;
  logic              in_acc;
  logic              do_load, do_start, do_inject;
  logic              empty, stop, fin;

  assign rank   = clamp_rank(axis_count_r);
  assign in_acc = in_ch.valid & in_ch.ready;

  // ready when not walking and the result register is free or leaving
  assign in_ch.ready = (state_r == ST_READY) & (~out_valid_r | out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.src_address = out_src_r;
  assign out_ch.dst_address = out_dst_r;
  assign out_ch.last        = out_last_r;

  // net offset change of a wrapping axis: stride minus stride times extent
  assign src_prod   = ADDR_W'(in_ch.src_stride * ADDR_W'(in_ch.extent));
  assign dst_prod   = ADDR_W'(in_ch.dst_stride * ADDR_W'(in_ch.extent));
  assign src_rewind = in_ch.src_stride - src_prod;
  assign dst_rewind = in_ch.dst_stride - dst_prod;

  // cell chain, carry runs from the last axis toward axis 0
  for (genvar i = 0; i < MAX_AXES; i++) begin : g_cell
    logic cin;

    if (i == MAX_AXES - 1) begin : g_end
      assign cin = 1'b0;
    end else begin : g_mid
      assign cin = carry[i+1];
    end

    assign ctl[i].load   = do_load & (int'(in_ch.axis) == i);
    assign ctl[i].clear  = do_start;
    assign ctl[i].inject = do_inject & (rank == RANK_W'(i + 1));

    dsag_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl[i]),
      .ld_extent     (in_ch.extent),
      .ld_src_stride (in_ch.src_stride),
      .ld_dst_stride (in_ch.dst_stride),
      .ld_src_rewind (src_rewind),
      .ld_dst_rewind (dst_rewind),
      .carry_in      (cin),
      .carry_out     (carry[i]),
      .stat          (stat[i]),
      .src_delta     (sdel[i]),
      .dst_delta     (ddel[i])
    );
  end

  // chain status: token stops, token leaves axis 0, empty active axis
  always_comb begin
    empty     = 1'b0;
    stop      = 1'b0;
    src_delta = '0;
    dst_delta = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      if ((rank > RANK_W'(i)) && stat[i].ext_zero) begin
        empty = 1'b1;
      end
      if (stat[i].tok && !stat[i].wrap) begin
        stop = 1'b1;
      end
      src_delta = src_delta | sdel[i];
      dst_delta = dst_delta | ddel[i];
    end
    fin = carry[0];
  end

  // sequencer next state and item handling
  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    src_off_nxt   = src_off_r;
    dst_off_nxt   = dst_off_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_src_nxt   = out_src_r;
    out_dst_nxt   = out_dst_r;
    out_last_nxt  = out_last_r;
    do_load       = 1'b0;
    do_start      = 1'b0;
    do_inject     = 1'b0;

    case (state_r)
      ST_READY: begin
        if (in_acc) begin
          case (op_t'(in_ch.opcode))
            OP_LOAD: begin
              do_load = 1'b1;
            end
            OP_START: begin
              do_start    = 1'b1;
              src_off_nxt = src_base_r;
              dst_off_nxt = dst_base_r;
              running_nxt = ~empty;
            end
            OP_STEP: begin
              if (running_r) begin
                out_src_nxt = src_off_r;
                out_dst_nxt = dst_off_r;
                if (rank == '0) begin
                  // no axes: single element, done at once
                  out_valid_nxt = 1'b1;
                  out_last_nxt  = 1'b1;
                  running_nxt   = 1'b0;
                end else begin
                  do_inject = 1'b1;
                  state_nxt = ST_WALK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        src_off_nxt = src_off_r + src_delta;
        dst_off_nxt = dst_off_r + dst_delta;
        if (stop || fin) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = fin;
          running_nxt   = ~fin;
          state_nxt     = ST_READY;
        end
      end
      default: begin
        state_nxt = ST_READY;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      running_r   <= 1'b0;
      src_off_r   <= '0;
      dst_off_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      src_off_r   <= src_off_nxt;
      dst_off_r   <= dst_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_src_r  <= out_src_nxt;
    out_dst_r  <= out_dst_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= AXIS_COUNT_W'(1);
      src_base_r   <= '0;
      dst_base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_AXIS_COUNT: axis_count_r <= cfg_wdata[AXIS_COUNT_W-1:0];
        CFG_SRC_BASE:   src_base_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_DST_BASE:   dst_base_r   <= cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/dsag_cell.sv =====
// ----------------------------------------------------------------------------
// dsag_cell: one axis of the address odometer
// Holds the axis descriptor and index counter. A carry token enters from
// the faster neighbor, the cell counts, and passes the token on when it wraps.
// ----------------------------------------------------------------------------
module dsag_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsag_pkg::cell_ctl_t           ctl,
  input  logic [dsag_pkg::EXTENT_W-1:0] ld_extent,
  input  logic [dsag_pkg::ADDR_W-1:0]   ld_src_stride,
  input  logic [dsag_pkg::ADDR_W-1:0]   ld_dst_stride,
  input  logic [dsag_pkg::ADDR_W-1:0]   ld_src_rewind,
  input  logic [dsag_pkg::ADDR_W-1:0]   ld_dst_rewind,
  input  logic                          carry_in,
  output logic                          carry_out,
  output dsag_pkg::cell_stat_t          stat,
  output logic [dsag_pkg::ADDR_W-1:0]   src_delta,
  output logic [dsag_pkg::ADDR_W-1:0]   dst_delta
);
  import dsag_pkg::*;

  logic [EXTENT_W-1:0] ext_r;
  logic [ADDR_W-1:0]   src_stride_r;
  logic [ADDR_W-1:0]   dst_stride_r;
  logic [ADDR_W-1:0]   src_rewind_r;
  logic [ADDR_W-1:0]   dst_rewind_r;
  logic [EXTENT_W-1:0] cnt_r;
  logic [EXTENT_W-1:0] cnt_nxt;
  logic                tok_r;
  logic                tok_nxt;
  logic [EXTENT_W-1:0] cnt_inc;
  logic                wrap;

  // descriptor storage, undefined until loaded
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ext_r        <= ld_extent;
      src_stride_r <= ld_src_stride;
      dst_stride_r <= ld_dst_stride;
      src_rewind_r <= ld_src_rewind;
      dst_rewind_r <= ld_dst_rewind;
    end
  end

  // counter wraps when the incremented index meets the extent
  assign cnt_inc = EXTENT_W'(cnt_r + 1'b1);
  assign wrap    = (cnt_inc == ext_r);

  // carry moves to the slower neighbor only on a wrap
  assign carry_out = tok_r & wrap;
  assign tok_nxt   = ctl.inject | carry_in;

  // offset change contributed by this axis while it holds the token
  assign src_delta = tok_r ? (wrap ? src_rewind_r : src_stride_r) : '0;
  assign dst_delta = tok_r ? (wrap ? dst_rewind_r : dst_stride_r) : '0;

  assign stat.tok      = tok_r;
  assign stat.wrap     = wrap;
  assign stat.ext_zero = (ext_r == '0);

  // index counter next value
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      cnt_nxt = '0;
    end else if (tok_r) begin
      cnt_nxt = wrap ? '0 : cnt_inc;
    end
  end

  // counter and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tok_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
    end
  end

endmodule

// ===== tb/tb_dual_strided_address_generator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_strided_address_generator_core: self-checking bench for the core
// Loads axis descriptors, starts traversals and steps them under random
// handshake gaps on both channels. Every address pair is predicted from a
// local odometer and compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_dual_strided_address_generator_core;
  import dsag_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1300;
  localparam int SETTLE_CYCLES = MAX_AXES + 4;

  // one expected source/destination pair
  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              last;
  } addr_pair_t;

  // odometer predictor plus the queue of pairs still owed by the core
  class addr_walk_board;
    logic [AXIS_COUNT_W-1:0] rank_reg;
    logic [ADDR_W-1:0]       src_base;
    logic [ADDR_W-1:0]       dst_base;
    logic [EXTENT_W-1:0]     ext_tab[MAX_AXES];
    logic [ADDR_W-1:0]       src_stride_tab[MAX_AXES];
    logic [ADDR_W-1:0]       dst_stride_tab[MAX_AXES];
    logic [EXTENT_W-1:0]     idx[MAX_AXES];
    logic [ADDR_W-1:0]       src_off;
    logic [ADDR_W-1:0]       dst_off;
    bit                      walking;
    addr_pair_t              due_pairs[$];
    int                      mismatches;

    function new();
      rank_reg = 1;
      src_base = '0;
      dst_base = '0;
      for (int a = 0; a < MAX_AXES; a++) begin
        ext_tab[a] = '0;
        src_stride_tab[a] = '0;
        dst_stride_tab[a] = '0;
        idx[a] = '0;
      end
      src_off = '0;
      dst_off = '0;
      walking = 0;
      mismatches = 0;
    endfunction

    function int active_rank();
      if (int'(rank_reg) > MAX_AXES) return MAX_AXES;
      return int'(rank_reg);
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        CFG_AXIS_COUNT: rank_reg = v[AXIS_COUNT_W-1:0];
        CFG_SRC_BASE:   src_base = v[ADDR_W-1:0];
        CFG_DST_BASE:   dst_base = v[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // innermost axis first, carry ripples toward axis 0; 1 when it leaves axis 0
    function bit advance_odometer();
      int a;
      logic [ADDR_W-1:0] ext32;
      a = active_rank();
      while (a > 0) begin
        a--;
        ext32 = {{(ADDR_W-EXTENT_W){1'b0}}, ext_tab[a]};
        src_off = src_off + src_stride_tab[a];
        dst_off = dst_off + dst_stride_tab[a];
        idx[a] = idx[a] + 1'b1;
        if (idx[a] != ext_tab[a]) return 0;
        idx[a] = '0;
        src_off = src_off - src_stride_tab[a] * ext32;
        dst_off = dst_off - dst_stride_tab[a] * ext32;
      end
      return 1;
    endfunction

    // returns 1 when the item does real work (load, start, step while walking)
    function bit note_command(logic [OPCODE_W-1:0] op, logic [AXIS_W-1:0] ax,
                              logic [EXTENT_W-1:0] ext, logic [ADDR_W-1:0] ss,
                              logic [ADDR_W-1:0] ds);
      addr_pair_t p;
      int r;
      case (op)
        OP_LOAD: begin
          ext_tab[ax] = ext;
          src_stride_tab[ax] = ss;
          dst_stride_tab[ax] = ds;
          return 1;
        end
        OP_START: begin
          for (int a = 0; a < MAX_AXES; a++) idx[a] = '0;
          src_off = src_base;
          dst_off = dst_base;
          walking = 1;
          r = active_rank();
          for (int a = 0; a < r; a++) begin
            if (ext_tab[a] == '0) walking = 0;
          end
          return 1;
        end
        OP_STEP: begin
          if (walking) begin
            p.src = src_off;
            p.dst = dst_off;
            p.last = advance_odometer();
            if (p.last) walking = 0;
            due_pairs = {due_pairs, p};
            return 1;
          end
        end
        default: ;
      endcase
      return 0;
    endfunction

    function void check_pair(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] d, logic l);
      addr_pair_t p;
      if (due_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pair: src %h dst %h last %b", s, d, l);
        return;
      end
      p = due_pairs.pop_front();
      if (p.src !== s || p.dst !== d || p.last !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: src exp %h got %h, dst exp %h got %h, last exp %b got %b",
                   p.src, s, p.dst, d, p.last, l);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  dsag_in_if  in_if();
  dsag_out_if out_if();

  dual_strided_address_generator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  addr_walk_board sb;
  bit calm;
  int items_done;
  int out_hold;
  int cycles;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_dual_strided_address_generator_core: done, errors");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom % 100;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_word();
    int roll;
    roll = $urandom % 10;
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom();
  endfunction

  // mostly tiny extents so traversals finish, plus zero, the maximum and random values
  function automatic logic [EXTENT_W-1:0] pick_extent();
    int roll;
    roll = $urandom % 100;
    if (roll < 50) return 1;
    if (roll < 70) return 2;
    if (roll < 80) return 3;
    if (roll < 85) return 4;
    if (roll < 90) return 0;
    if (roll < 95) return '1;
    return EXTENT_W'($urandom_range(0, 65535));
  endfunction

  // result side: check accepted pairs, stall ready at random
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_pair(out_if.src_address, out_if.dst_address, out_if.last);
    if (out_hold > 0) begin
      out_hold--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_hold = pick_gap();
    end
  end

  task automatic in_pause();
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // present one command item and hold it until accepted
  task automatic put_item(input logic [OPCODE_W-1:0] op, input logic [AXIS_W-1:0] ax,
                          input logic [EXTENT_W-1:0] ext, input logic [ADDR_W-1:0] ss,
                          input logic [ADDR_W-1:0] ds);
    in_pause();
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.axis       <= ax;
    in_if.extent     <= ext;
    in_if.src_stride <= ss;
    in_if.dst_stride <= ds;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (sb.note_command(op, ax, ext, ss, ds)) items_done++;
  endtask

  // non-load items carry random payload bits
  task automatic put_cmd(input logic [OPCODE_W-1:0] op);
    put_item(op, AXIS_W'($urandom()), EXTENT_W'($urandom()), $urandom(), $urandom());
  endtask

  task automatic put_load(input int ax);
    put_item(OP_LOAD, AXIS_W'(ax), pick_extent(), pick_word(), pick_word());
  endtask

  // let every owed pair arrive, then let any step still walking finish
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.due_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // no item is offered while a register is written
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    in_if.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(r, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // new rank (extremes and saturating values included) and new bases
  task automatic config_phase();
    int roll;
    logic [AXIS_COUNT_W-1:0] rank;
    drain();
    roll = $urandom % 8;
    case (roll)
      0: rank = 0;
      1: rank = 1;
      2: rank = AXIS_COUNT_W'(MAX_AXES);
      3: rank = '1;
      4: rank = AXIS_COUNT_W'($urandom_range(MAX_AXES + 1, 15));
      default: rank = AXIS_COUNT_W'($urandom_range(1, MAX_AXES));
    endcase
    write_reg(CFG_AXIS_COUNT, ($urandom() & ~32'hF) | CFG_DATA_W'(rank));
    write_reg(CFG_SRC_BASE, pick_word());
    write_reg(CFG_DST_BASE, pick_word());
    calm = ($urandom % 4 == 0);
  endtask

  // reload part of the table, start, and step through the traversal
  task automatic run_sequence();
    int r;
    int cap;
    int n;
    int roll;
    r = sb.active_rank();
    for (int a = 0; a < MAX_AXES; a++) begin
      if ($urandom % 100 < (a < r ? 70 : 15)) put_load(a);
    end
    if ($urandom % 10 != 0) put_cmd(OP_START);
    cap = $urandom_range(20, 200);
    n = 0;
    while (sb.walking && n < cap) begin
      roll = $urandom % 40;
      case (roll)
        0: put_load($urandom_range(0, MAX_AXES - 1));
        1: put_cmd(OP_UNUSED);
        2: put_cmd(OP_START);
        default: put_cmd(OP_STEP);
      endcase
      n++;
    end
    if ($urandom % 3 == 0) put_cmd(OP_STEP);
  endtask

  initial begin
    int seq_count;
    sb = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_AXIS_COUNT;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_LOAD;
    in_if.axis       = '0;
    in_if.extent     = '0;
    in_if.src_stride = '0;
    in_if.dst_stride = '0;
    out_if.ready     = 1'b0;
    calm = 0;
    items_done = 0;
    out_hold = 0;
    cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step while idle and the unused opcode: both ignored
    put_cmd(OP_STEP);
    put_cmd(OP_UNUSED);

    // full table, 2 x 3 traversal with wrapping strides, restart mid-way
    write_reg(CFG_AXIS_COUNT, 2);
    write_reg(CFG_SRC_BASE, 32'hFFFF_FFFE);
    write_reg(CFG_DST_BASE, '0);
    put_item(OP_LOAD, 0, 2, 32'hFFFF_FFFF, 32'h0000_0000);
    put_item(OP_LOAD, 1, 3, 32'h0000_0004, 32'h8000_0000);
    for (int a = 2; a < MAX_AXES; a++) put_item(OP_LOAD, AXIS_W'(a), 1, $urandom(), $urandom());
    put_cmd(OP_START);
    repeat (2) put_cmd(OP_STEP);
    put_cmd(OP_START);
    repeat (6) put_cmd(OP_STEP);

    // rank zero: one element at the bases, then idle
    drain();
    write_reg(CFG_AXIS_COUNT, 0);
    put_cmd(OP_START);
    repeat (2) put_cmd(OP_STEP);

    // rank above the cell count saturates; maximum extent, then an empty axis
    drain();
    write_reg(CFG_AXIS_COUNT, 15);
    put_item(OP_LOAD, 6, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    put_cmd(OP_START);
    repeat (3) put_cmd(OP_STEP);
    put_item(OP_LOAD, 6, 1, $urandom(), $urandom());
    put_item(OP_LOAD, 5, 0, $urandom(), $urandom());
    put_cmd(OP_START);
    put_cmd(OP_STEP);

    // random sequences with periodic reconfiguration
    seq_count = 0;
    while (items_done < ITEM_TARGET) begin
      seq_count++;
      if (seq_count % 12 == 0) config_phase();
      run_sequence();
    end

    drain();
    if (sb.mismatches == 0 && sb.due_pairs.size() == 0)
      $display("tb_dual_strided_address_generator_core: done, clean");
    else
      $display("tb_dual_strided_address_generator_core: done, errors");
    $finish;
  end

endmodule
